### rtl/core/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// shared constants and the tempering function of the twisted gfsr generator
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int STATE_WORDS     = 25;
    localparam int FEEDBACK_OFFSET = 7;

    // index into the word store, and position that can also hold STATE_WORDS
    localparam int IDX_W = $clog2(STATE_WORDS);
    localparam int POS_W = $clog2(STATE_WORDS + 1);

    localparam int WORD_W      = 32;
    localparam int WORD_IDX_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WORD_W-1:0] TEMPER_MASK_A   = 32'h0056_b64a;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B   = 32'hffff_b716;
    localparam logic [WORD_W-1:0] TWIST_EVEN_RST  = 32'h0000_0000;
    localparam logic [WORD_W-1:0] TWIST_ODD_RST   = 32'h8ebf_d028;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWIST_EVEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TWIST_ODD  = 1'b1;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ ((y & TEMPER_MASK_A) << 7);
        y = y ^ ((y & TEMPER_MASK_B) << 15);
        y = y ^ (y >> 16);
        return y;
    endfunction

endpackage

### rtl/core/twisted_gfsr_random_generator_top.sv
// ----------------------------------------------------------------------------
// twisted_gfsr_random_generator_top
// tt800-style twisted gfsr generator with its word store in a small ram
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one state word, or nothing for an index
// past the store, and the next draw then regenerates the whole store. A draw
// transaction (mode 1) reads its word from the ram and then loads the tempered
// word into the result register, after a full regeneration when one is due;
// in_stall stays high until the result is registered, so a new draw is not
// taken before the last one is through. Regeneration walks the store word by
// word: one cycle reads the word and the word FEEDBACK_OFFSET places ahead
// on the two read ports of the ram, the next cycle writes the updated word
// back. One item is worked on at a time; the result register lets the next
// transaction be accepted while a result still waits on out_stall. The store
// reads as zero after reset through per-word valid bits, so no clearing pass
// is needed. The user must write twist_even and twist_odd only while the
// block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module twisted_gfsr_random_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgr_pkg::WORD_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [tgr_pkg::WORD_IDX_W-1:0]    word_index,
    input  logic [tgr_pkg::WORD_W-1:0]        word_value,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tgr_pkg::WORD_W-1:0]        random_word
);
    import tgr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REGEN_RD,
        ST_REGEN_WR,
        ST_DRAW
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     regen_idx_reg, regen_idx_next;
    logic [WORD_W-1:0]    twist_even_reg, twist_even_next;
    logic [WORD_W-1:0]    twist_odd_reg, twist_odd_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    out_word_reg, out_word_next;
    logic [STATE_WORDS-1:0] word_valid_reg, word_valid_next;
    logic                 rd_a_valid_reg, rd_a_valid_next;
    logic                 rd_b_valid_reg, rd_b_valid_next;

    // word store: one write port, two registered read ports
    logic [WORD_W-1:0]    store_mem [STATE_WORDS];
    logic [WORD_W-1:0]    rd_a_data_reg, rd_b_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     rd_a_addr, rd_b_addr;

    logic                 in_accept;
    logic                 out_free;
    logic [WORD_W-1:0]    word_a, word_b, regen_word;
    logic [IDX_W:0]       ahead_sum;
    logic [IDX_W-1:0]     ahead_idx;
    logic [IDX_W-1:0]     load_idx;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // words never written read as zero
    assign word_a = rd_a_valid_reg ? rd_a_data_reg : '0;
    assign word_b = rd_b_valid_reg ? rd_b_data_reg : '0;

    // next state of the current word, twist picked by its old low bit
    assign regen_word = (word_a >> 1) ^ (word_a[0] ? twist_odd_reg : twist_even_reg) ^ word_b;

    // cyclic index of the feedback word
    assign ahead_sum = {1'b0, regen_idx_reg} + (IDX_W + 1)'(FEEDBACK_OFFSET);
    assign ahead_idx = (ahead_sum >= (IDX_W + 1)'(STATE_WORDS))
                     ? IDX_W'(ahead_sum - (IDX_W + 1)'(STATE_WORDS))
                     : ahead_sum[IDX_W-1:0];

    assign load_idx = IDX_W'(word_index);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        regen_idx_next  = regen_idx_reg;
        twist_even_next = twist_even_reg;
        twist_odd_next  = twist_odd_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        word_valid_next = word_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = regen_idx_reg;
        mem_wdata       = regen_word;
        mem_re          = 1'b0;
        rd_a_addr       = pos_reg[IDX_W-1:0];
        rd_b_addr       = ahead_idx;

        // result register drains on a completed output transaction
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TWIST_EVEN: twist_even_next = cfg_data;
                REG_TWIST_ODD:  twist_odd_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        // out-of-range index writes nothing but still forces regen
                        if (int'(word_index) < STATE_WORDS)
                        begin
                            mem_we                    = 1'b1;
                            mem_waddr                 = load_idx;
                            mem_wdata                 = word_value;
                            word_valid_next[load_idx] = 1'b1;
                        end
                        pos_next = POS_W'(STATE_WORDS);
                    end
                    else if (pos_reg == POS_W'(STATE_WORDS))
                    begin
                        regen_idx_next = '0;
                        state_next     = ST_REGEN_RD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_DRAW;
                    end
                end
            end

            ST_REGEN_RD:
            begin
                // fetch the word and its feedback partner
                mem_re     = 1'b1;
                rd_a_addr  = regen_idx_reg;
                state_next = ST_REGEN_WR;
            end

            ST_REGEN_WR:
            begin
                mem_we                         = 1'b1;
                word_valid_next[regen_idx_reg] = 1'b1;
                if (regen_idx_reg == IDX_W'(STATE_WORDS - 1))
                begin
                    // store refreshed, start the draw at word zero
                    pos_next   = '0;
                    mem_re     = 1'b1;
                    rd_a_addr  = '0;
                    state_next = ST_DRAW;
                end
                else
                begin
                    regen_idx_next = regen_idx_reg + 1'b1;
                    state_next     = ST_REGEN_RD;
                end
            end

            ST_DRAW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = temper(word_a);
                    pos_next       = pos_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        rd_a_valid_next = mem_re ? word_valid_reg[rd_a_addr] : rd_a_valid_reg;
        rd_b_valid_next = mem_re ? word_valid_reg[rd_b_addr] : rd_b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= POS_W'(STATE_WORDS);
            regen_idx_reg  <= '0;
            twist_even_reg <= TWIST_EVEN_RST;
            twist_odd_reg  <= TWIST_ODD_RST;
            out_valid_reg  <= 1'b0;
            word_valid_reg <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            regen_idx_reg  <= regen_idx_next;
            twist_even_reg <= twist_even_next;
            twist_odd_reg  <= twist_odd_next;
            out_valid_reg  <= out_valid_next;
            word_valid_reg <= word_valid_next;
            rd_a_valid_reg <= rd_a_valid_next;
            rd_b_valid_reg <= rd_b_valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // word store ram
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_data_reg <= store_mem[rd_a_addr];
            rd_b_data_reg <= store_mem[rd_b_addr];
        end
    end

endmodule

### verif/twisted_gfsr_random_generator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twisted_gfsr_random_generator_checker
// watches the item and result channels of the twisted gfsr generator, keeps
// its own copy of the word store and twist words, and compares every result
// ----------------------------------------------------------------------------
module twisted_gfsr_random_generator_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgr_pkg::WORD_W-1:0]        cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              mode,
    input  logic [tgr_pkg::WORD_IDX_W-1:0]    word_index,
    input  logic [tgr_pkg::WORD_W-1:0]        word_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [tgr_pkg::WORD_W-1:0]        random_word,
    output int                                error_count,
    output int                                words_outstanding,
    output int                                words_checked
);
    import tgr_pkg::*;

    logic [WORD_W-1:0] shadow_words [STATE_WORDS];
    int unsigned       shadow_position;
    logic [WORD_W-1:0] shadow_twist_even;
    logic [WORD_W-1:0] shadow_twist_odd;
    logic [WORD_W-1:0] awaited_random_words [$];

    // one full pass of the recurrence, later words see already updated ones
    function automatic void regenerate_shadow_store();
        logic [WORD_W-1:0] current;
        logic [WORD_W-1:0] ahead;
        logic [WORD_W-1:0] twist;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            current = shadow_words[k];
            ahead   = shadow_words[(k + FEEDBACK_OFFSET) % STATE_WORDS];
            twist   = current[0] ? shadow_twist_odd : shadow_twist_even;
            shadow_words[k] = (current >> 1) ^ twist ^ ahead;
        end
        shadow_position = 0;
    endfunction

    function automatic logic [WORD_W-1:0] tempered_output(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] y;
        y = raw;
        y = y ^ ((y & 32'h0056_b64a) << 7);
        y = y ^ ((y & 32'hffff_b716) << 15);
        y = y ^ (y >> 16);
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] awaited;
        if (!rst_n)
        begin
            for (int k = 0; k < STATE_WORDS; k++)
                shadow_words[k] = '0;
            shadow_position   = STATE_WORDS;
            shadow_twist_even = TWIST_EVEN_RST;
            shadow_twist_odd  = TWIST_ODD_RST;
            awaited_random_words.delete();
            error_count       = 0;
            words_outstanding = 0;
            words_checked     = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TWIST_EVEN: shadow_twist_even = cfg_data;
                    REG_TWIST_ODD:  shadow_twist_odd  = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (awaited_random_words.size() == 0)
                begin
                    $error("random_word: unexpected transaction, actual %h", random_word);
                    error_count++;
                end
                else
                begin
                    awaited = awaited_random_words.pop_front();
                    if (random_word !== awaited)
                    begin
                        $error("random_word mismatch: expected %h, actual %h",
                               awaited, random_word);
                        error_count++;
                    end
                    words_checked++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (mode == MODE_LOAD)
                begin
                    if (word_index < STATE_WORDS)
                        shadow_words[word_index] = word_value;
                    shadow_position = STATE_WORDS;
                end
                else
                begin
                    if (shadow_position >= STATE_WORDS)
                        regenerate_shadow_store();
                    awaited_random_words.push_back(
                        tempered_output(shadow_words[shadow_position]));
                    shadow_position++;
                end
            end

            words_outstanding = awaited_random_words.size();
        end
    end

endmodule

### verif/twisted_gfsr_random_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twisted_gfsr_random_generator_top_test
// drives load and draw transactions into the twisted gfsr generator under
// several twist settings, with random sender bursts and receiver stalls; the
// checker beside the block predicts and compares every random word
// ----------------------------------------------------------------------------
module twisted_gfsr_random_generator_top_test;
    import tgr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 5;
    localparam int ITEMS_PER_PHASE = 180;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   mode;
    logic [WORD_IDX_W-1:0]  word_index;
    logic [WORD_W-1:0]      word_value;
    logic                   out_valid;
    logic                   out_stall;
    logic [WORD_W-1:0]      random_word;

    int error_count;
    int words_outstanding;
    int words_checked;

    int cycle_count;
    int burst_left;
    int load_count;
    int draw_count;
    int settings_used;
    bit pressure_req;
    bit pressure_done;

    twisted_gfsr_random_generator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .word_index  (word_index),
        .word_value  (word_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    twisted_gfsr_random_generator_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .word_index        (word_index),
        .word_value        (word_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .random_word       (random_word),
        .error_count       (error_count),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    // clock and a known value on every input from time zero
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_TWIST_EVEN;
        cfg_data   = '0;
        in_valid   = 1'b0;
        mode       = MODE_LOAD;
        word_index = '0;
        word_value = '0;
        out_stall  = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog, counts every cycle of the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial cycle_count = 0;

    // receiver: segments of free flow, random stalls and solid stalls, plus
    // one long hold-off so the block backs up and raises in_stall
    initial
    begin
        int kind;
        int seg_len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (pressure_req && !pressure_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                pressure_done = 1'b1;
            end
            else
            begin
                kind    = $urandom_range(0, 3);
                seg_len = $urandom_range(5, 40);
                for (int k = 0; k < seg_len; k++)
                begin
                    case (kind)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= (k < 12);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // random word, now and then an all-zero or all-one value
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // offer one transaction and hold it until accepted; idle gaps come
    // between bursts of random length
    task automatic send_item(input logic item_mode, input logic [WORD_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] value);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // a quarter of the bursts are long stretches with no idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        mode       <= item_mode;
        word_index <= idx;
        word_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (item_mode == MODE_LOAD)
            load_count++;
        else
            draw_count++;
    endtask

    task automatic send_draw();
        send_item(MODE_DRAW, WORD_IDX_W'($urandom_range(0, 31)), pick_word());
    endtask

    // stop offering, let every awaited word come out, then give loads and
    // the last regeneration time to finish
    task automatic drain_block();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (words_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_items();
        // zero store after reset: draws give zero, the fields are ignored
        send_item(MODE_DRAW, 5'd31, 32'hffff_ffff);
        send_item(MODE_DRAW, 5'd0, 32'h0000_0000);
        // field extremes, including loads past the end of the store
        send_item(MODE_LOAD, 5'd0, 32'hffff_ffff);
        send_item(MODE_LOAD, 5'd24, 32'h0000_0001);
        send_item(MODE_LOAD, 5'd25, $urandom);
        send_item(MODE_LOAD, 5'd31, 32'hffff_ffff);
        send_item(MODE_LOAD, 5'd12, 32'h8000_0000);
        repeat (3) send_draw();
        // load in the middle of a run forces a fresh regeneration
        send_item(MODE_LOAD, 5'd7, 32'h0000_0000);
        send_draw();
        // out-of-range load writes nothing but still restarts the store
        send_item(MODE_LOAD, 5'd30, $urandom);
        repeat (12) send_draw();
    endtask

    // mostly complete seedings followed by draw runs that cross the
    // regeneration boundary, with stray loads and partial seedings mixed in
    task automatic random_items(input int target);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                send_item(MODE_LOAD, WORD_IDX_W'($urandom_range(0, 31)), pick_word());
                sent++;
            end
            else if (pick < 18)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_item(MODE_LOAD,
                                     WORD_IDX_W'($urandom_range(0, STATE_WORDS - 1)),
                                     pick_word());
                repeat ($urandom_range(1, 4)) send_draw();
                sent += n;
            end
            else if (pick < 38)
            begin
                for (int k = 0; k < STATE_WORDS; k++)
                    send_item(MODE_LOAD, WORD_IDX_W'(k), pick_word());
                sent += STATE_WORDS;
            end
            else
            begin
                n = $urandom_range(1, 40);
                repeat (n) send_draw();
                sent += n;
            end
        end
    endtask

    initial
    begin
        burst_left    = 0;
        load_count    = 0;
        draw_count    = 0;
        settings_used = 1;
        pressure_req  = 1'b0;
        pressure_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first setting is the reset value of both twist words
        directed_items();
        pressure_req = 1'b1;
        random_items(ITEMS_PER_PHASE);
        drain_block();

        for (int phase = 1; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_register(REG_TWIST_EVEN, 32'hffff_ffff);
                    write_register(REG_TWIST_ODD, 32'h0000_0000);
                end
                2:
                begin
                    write_register(REG_TWIST_EVEN, 32'h0000_0000);
                    write_register(REG_TWIST_ODD, 32'hffff_ffff);
                end
                default:
                begin
                    write_register(REG_TWIST_EVEN, $urandom);
                    write_register(REG_TWIST_ODD, $urandom);
                end
            endcase
            settings_used++;
            // a few draws straight away on the store left by the last phase
            repeat (3) send_draw();
            random_items(ITEMS_PER_PHASE);
            drain_block();
        end

        $display("covered %0d loads and %0d draws over %0d twist settings",
                 load_count, draw_count, settings_used);
        $display("compared %0d random words, receiver held off once for %0d cycles",
                 words_checked, LONG_HOLD);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
